/* src/cgcv_pkg.sv */
package cgcv_pkg;

  localparam int REG_W    = 24;
  localparam int GRID_W   = 9;
  localparam int D_W      = 9;
  localparam int T_W      = 11;
  localparam int FN_W     = 12;
  localparam int IDXP_W   = 21;
  localparam int IDX_W    = 19;
  localparam int COORD_W  = 25;
  localparam int QW       = 25;
  localparam int P1_W     = REG_W + T_W;
  localparam int DIV1_W   = 11;
  localparam int DIV1_NW  = QW + DIV1_W;
  localparam int DIV2_W   = 27;
  localparam int DIV2_NW  = QW + DIV2_W;
  localparam int SQ_W     = 2 * QW;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [REG_W-1:0]  RADIUS_RST = 24'd65536;
  localparam logic [REG_W-1:0]  HEIGHT_RST = 24'd65536;
  localparam logic [GRID_W-1:0] GRID_RST   = 9'd16;
  localparam logic [GRID_W-1:0] GRID_MIN   = 9'd2;

  typedef enum logic [2:0] {
    FACE_BOTTOM = 3'd0,
    FACE_TOP    = 3'd1,
    FACE_YPOS   = 3'd2,
    FACE_YNEG   = 3'd3,
    FACE_XNEG   = 3'd4,
    FACE_XPOS   = 3'd5
  } face_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_GRID   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             ok;
    logic             side;
    logic             sx;
    logic             sy;
    logic             sz;
    logic [IDX_W-1:0] idx;
  } div1_side_t;

  typedef struct packed {
    logic               ok;
    logic               sx;
    logic               sy;
    logic [QW-1:0]      qx;
    logic [QW-1:0]      qy;
    logic [QW-1:0]      k;
    logic [COORD_W-1:0] z;
    logic [IDX_W-1:0]   idx;
  } sqrt_side_t;

  typedef struct packed {
    logic               ok;
    logic               sx;
    logic               sy;
    logic               zero_len;
    logic [QW-1:0]      qx;
    logic [QW-1:0]      qy;
    logic [COORD_W-1:0] z;
    logic [IDX_W-1:0]   idx;
  } div2_side_t;

endpackage

/* src/cgcv_rdiv.sv */
module cgcv_rdiv #(
  parameter int LANES = 1,
  parameter int QW    = 25,
  parameter int DW    = 11,
  parameter int SW    = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][QW+DW-1:0]    num,
  input  logic [LANES-1:0][DW-1:0]       div,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic [LANES-1:0][QW-1:0]       quo,
  output logic [SW-1:0]                  out_side
);

  logic                        vld_q  [1:QW];
  logic [LANES-1:0][DW-1:0]    rem_q  [1:QW];
  logic [LANES-1:0][DW-1:0]    dv_q   [1:QW];
  logic [LANES-1:0][QW-1:0]    low_q  [1:QW];
  logic [SW-1:0]               side_q [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [LANES-1:0][DW-1:0] c_rem;
    logic [LANES-1:0][DW-1:0] c_dv;
    logic [LANES-1:0][DW-1:0] n_rem;
    logic [LANES-1:0][QW-1:0] c_low;
    logic [LANES-1:0][QW-1:0] n_low;
    logic                     c_vld;
    logic [SW-1:0]            c_side;

    if (s == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          c_rem[l] = num[l][QW+DW-1:QW];
          c_low[l] = num[l][QW-1:0];
        end
      end
      assign c_dv   = div;
      assign c_vld  = in_valid;
      assign c_side = in_side;
    end else begin : g_body
      assign c_rem  = rem_q[s];
      assign c_low  = low_q[s];
      assign c_dv   = dv_q[s];
      assign c_vld  = vld_q[s];
      assign c_side = side_q[s];
    end

    always_comb begin
      logic [DW:0] t;
      logic [DW:0] nt;
      for (int l = 0; l < LANES; l++) begin
        t  = {c_rem[l], c_low[l][QW-1]};
        nt = t - {1'b0, c_dv[l]};
        if (t >= {1'b0, c_dv[l]}) begin
          n_rem[l] = nt[DW-1:0];
          n_low[l] = {c_low[l][QW-2:0], 1'b1};
        end else begin
          n_rem[l] = t[DW-1:0];
          n_low[l] = {c_low[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1]  <= n_rem;
        low_q[s+1]  <= n_low;
        dv_q[s+1]   <= c_dv;
        side_q[s+1] <= c_side;
      end
    end
  end

  assign out_valid = vld_q[QW];
  assign quo       = low_q[QW];
  assign out_side  = side_q[QW];

endmodule

/* src/cgcv_isqrt.sv */
module cgcv_isqrt #(
  parameter int RW = 25,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] val,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  localparam int VW  = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int TW  = RW + 4;

  logic           vld_q  [1:RW];
  logic [RMW-1:0] rem_q  [1:RW];
  logic [RW-1:0]  root_q [1:RW];
  logic [VW-1:0]  low_q  [1:RW];
  logic [SW-1:0]  side_q [1:RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RMW-1:0] c_rem;
    logic [RW-1:0]  c_root;
    logic [VW-1:0]  c_low;
    logic           c_vld;
    logic [SW-1:0]  c_side;
    logic [TW-1:0]  t;
    logic [TW-1:0]  sub;
    logic [TW-1:0]  nt;
    logic           ge;

    if (s == 0) begin : g_head
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_low  = val;
      assign c_vld  = in_valid;
      assign c_side = in_side;
    end else begin : g_body
      assign c_rem  = rem_q[s];
      assign c_root = root_q[s];
      assign c_low  = low_q[s];
      assign c_vld  = vld_q[s];
      assign c_side = side_q[s];
    end

    assign t   = {c_rem, c_low[VW-1 -: 2]};
    assign sub = TW'({c_root, 2'b01});
    assign ge  = (t >= sub);
    assign nt  = ge ? (t - sub) : t;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1]  <= nt[RMW-1:0];
        root_q[s+1] <= {c_root[RW-2:0], ge};
        low_q[s+1]  <= {c_low[VW-3:0], 2'b00};
        side_q[s+1] <= c_side;
      end
    end
  end

  assign out_valid = vld_q[RW];
  assign root      = root_q[RW];
  assign out_side  = side_q[RW];

endmodule

/* src/cube_grid_to_cylinder_vertex_core.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    face, row, col
// output    out_valid / out_stall  x_out, y_out, z_out, vertex_index
// config    APB write/read         radius, height, grid_points
//
// One grid point is taken in every cycle while in_stall is low.
// The datapath holds three one-bit-per-stage pipelines: two dividers and a
// square root of 25 stages each, plus five arithmetic stages.
// Reset clears all valid bits and loads the register defaults; there is no
// clearing pass. A stalled result sits in an output skid register, and input
// stall rises only while that register holds a result.
module cube_grid_to_cylinder_vertex_core #(
  parameter int MAX_GRID = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cgcv_pkg::ADDR_W-1:0]       paddr,
  input  logic [cgcv_pkg::DATA_W-1:0]       pwdata,
  output logic [cgcv_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        face,
  input  logic [7:0]                        row,
  input  logic [7:0]                        col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cgcv_pkg::COORD_W-1:0] x_out,
  output logic signed [cgcv_pkg::COORD_W-1:0] y_out,
  output logic signed [cgcv_pkg::COORD_W-1:0] z_out,
  output logic [cgcv_pkg::IDX_W-1:0]        vertex_index
);
  import cgcv_pkg::*;

  logic [REG_W-1:0]  radius;
  logic [REG_W-1:0]  height;
  logic [GRID_W-1:0] grid_points;
  reg_idx_t          widx;
  logic              en;
  logic              skid_full;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RST;
      height      <= HEIGHT_RST;
      grid_points <= GRID_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_RADIUS: radius <= pwdata[REG_W-1:0];
        REG_HEIGHT: height <= pwdata[REG_W-1:0];
        REG_GRID:   grid_points <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_RADIUS: prdata = DATA_W'(radius);
      REG_HEIGHT: prdata = DATA_W'(height);
      REG_GRID:   prdata = DATA_W'(grid_points);
      default:    prdata = '0;
    endcase
  end

  assign en       = !skid_full;
  assign in_stall = skid_full;

  // Stage 1: clamp the grid and place the point on its face.
  logic [GRID_W-1:0]   n_c;
  logic [D_W-1:0]      d_c;
  logic [7:0]          row_c;
  logic [7:0]          col_c;
  logic signed [T_W-1:0] dp;
  logic signed [T_W-1:0] a_c;
  logic signed [T_W-1:0] b_c;
  logic signed [T_W-1:0] tx_c;
  logic signed [T_W-1:0] ty_c;
  logic signed [T_W-1:0] tz_c;
  logic [T_W-1:0]      tz_abs;
  logic                ok_c;
  logic                side_c;
  logic [FN_W-1:0]     fn_c;

  always_comb begin
    if (grid_points < GRID_MIN) begin
      n_c = GRID_MIN;
    end else if (32'(grid_points) > MAX_GRID) begin
      n_c = GRID_W'(MAX_GRID);
    end else begin
      n_c = grid_points;
    end
    d_c   = n_c - GRID_W'(1);
    row_c = ({1'b0, row} > d_c) ? d_c[7:0] : row;
    col_c = ({1'b0, col} > d_c) ? d_c[7:0] : col;
    dp    = $signed({2'b00, d_c});
    a_c   = $signed({2'b00, row_c, 1'b0}) - dp;
    b_c   = $signed({2'b00, col_c, 1'b0}) - dp;
    ok_c  = 1'b1;
    case (face)
      FACE_BOTTOM: begin tx_c = a_c; ty_c = b_c; tz_c = -dp; end
      FACE_TOP:    begin tx_c = a_c; ty_c = b_c; tz_c = dp;  end
      FACE_YPOS:   begin tx_c = a_c; ty_c = dp;  tz_c = b_c; end
      FACE_YNEG:   begin tx_c = a_c; ty_c = -dp; tz_c = b_c; end
      FACE_XNEG:   begin tx_c = -dp; ty_c = a_c; tz_c = b_c; end
      FACE_XPOS:   begin tx_c = dp;  ty_c = a_c; tz_c = b_c; end
      default: begin
        tx_c = '0;
        ty_c = '0;
        tz_c = '0;
        ok_c = 1'b0;
      end
    endcase
    tz_abs = tz_c[T_W-1] ? $unsigned(-tz_c) : $unsigned(tz_c);
    side_c = (height != '0) && (tz_abs < {2'b00, d_c});
    fn_c   = FN_W'(face) * FN_W'(n_c) + FN_W'(row_c);
  end

  logic                  v1;
  logic                  ok1;
  logic                  side1;
  logic [D_W-1:0]        d1;
  logic signed [T_W-1:0] tx1;
  logic signed [T_W-1:0] ty1;
  logic signed [T_W-1:0] tz1;
  logic [FN_W-1:0]       fn1;
  logic [GRID_W-1:0]     n1;
  logic [7:0]            col1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1   <= ok_c;
      side1 <= side_c;
      d1    <= d_c;
      tx1   <= tx_c;
      ty1   <= ty_c;
      tz1   <= tz_c;
      fn1   <= fn_c;
      n1    <= n_c;
      col1  <= col_c;
    end
  end

  // Stage 2: scale to the box and form the rounding numerators.
  logic [T_W-1:0]   mx;
  logic [T_W-1:0]   my;
  logic [T_W-1:0]   mz;
  logic [P1_W-1:0]  prodx;
  logic [P1_W-1:0]  prody;
  logic [P1_W-1:0]  prodz;
  logic [IDXP_W-1:0] idx_c;
  div1_side_t       sb2_c;

  always_comb begin
    mx    = tx1[T_W-1] ? $unsigned(-tx1) : $unsigned(tx1);
    my    = ty1[T_W-1] ? $unsigned(-ty1) : $unsigned(ty1);
    mz    = tz1[T_W-1] ? $unsigned(-tz1) : $unsigned(tz1);
    prodx = P1_W'(radius) * P1_W'(mx);
    prody = P1_W'(radius) * P1_W'(my);
    prodz = P1_W'(height) * P1_W'(mz);
    idx_c = IDXP_W'(fn1) * IDXP_W'(n1) + IDXP_W'(col1);
    sb2_c.ok   = ok1;
    sb2_c.side = side1;
    sb2_c.sx   = tx1[T_W-1];
    sb2_c.sy   = ty1[T_W-1];
    sb2_c.sz   = tz1[T_W-1];
    sb2_c.idx  = idx_c[IDX_W-1:0];
  end

  logic                            v2;
  logic [2:0][DIV1_NW-1:0]         num2;
  logic [2:0][DIV1_W-1:0]          div2;
  div1_side_t                      sb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2[0] <= {prodx, 1'b0} + DIV1_NW'(d1);
      num2[1] <= {prody, 1'b0} + DIV1_NW'(d1);
      num2[2] <= {prodz, 1'b0} + DIV1_NW'({d1, 1'b0});
      div2[0] <= DIV1_W'({d1, 1'b0});
      div2[1] <= DIV1_W'({d1, 1'b0});
      div2[2] <= {d1, 2'b00};
      sb2     <= sb2_c;
    end
  end

  logic                   vd1;
  logic [2:0][QW-1:0]     q1;
  div1_side_t             sbd1;

  cgcv_rdiv #(
    .LANES(3),
    .QW   (QW),
    .DW   (DIV1_W),
    .SW   ($bits(div1_side_t))
  ) u_div_box (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .num      (num2),
    .div      (div2),
    .in_side  (sb2),
    .out_valid(vd1),
    .quo      (q1),
    .out_side (sbd1)
  );

  // Stage 3: squares and the target length factor.
  logic [QW-1:0] kmax;
  sqrt_side_t    sb3_c;

  always_comb begin
    kmax = (q1[0] > q1[1]) ? q1[0] : q1[1];
    sb3_c.ok  = sbd1.ok;
    sb3_c.sx  = sbd1.sx;
    sb3_c.sy  = sbd1.sy;
    sb3_c.qx  = q1[0];
    sb3_c.qy  = q1[1];
    sb3_c.k   = sbd1.side ? QW'(radius) : kmax;
    sb3_c.z   = sbd1.sz ? (COORD_W'(0) - q1[2]) : q1[2];
    sb3_c.idx = sbd1.idx;
  end

  logic            v3;
  logic [SQ_W-1:0] sqx3;
  logic [SQ_W-1:0] sqy3;
  sqrt_side_t      sb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3 <= SQ_W'(q1[0]) * SQ_W'(q1[0]);
      sqy3 <= SQ_W'(q1[1]) * SQ_W'(q1[1]);
      sb3  <= sb3_c;
    end
  end

  logic          vs;
  logic [QW-1:0] len;
  sqrt_side_t    sbs;

  cgcv_isqrt #(
    .RW(QW),
    .SW($bits(sqrt_side_t))
  ) u_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .val      (sqx3 + sqy3),
    .in_side  (sb3),
    .out_valid(vs),
    .root     (len),
    .out_side (sbs)
  );

  // Stage 5: numerators for the push out to the circle.
  logic [SQ_W-1:0] mulx;
  logic [SQ_W-1:0] muly;
  div2_side_t      sb5_c;

  always_comb begin
    mulx = SQ_W'(sbs.qx) * SQ_W'(sbs.k);
    muly = SQ_W'(sbs.qy) * SQ_W'(sbs.k);
    sb5_c.ok       = sbs.ok;
    sb5_c.sx       = sbs.sx;
    sb5_c.sy       = sbs.sy;
    sb5_c.zero_len = (len == '0);
    sb5_c.qx       = sbs.qx;
    sb5_c.qy       = sbs.qy;
    sb5_c.z        = sbs.z;
    sb5_c.idx      = sbs.idx;
  end

  logic                      v5;
  logic [1:0][DIV2_NW-1:0]   num5;
  logic [1:0][DIV2_W-1:0]    div5;
  div2_side_t                sb5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5[0] <= DIV2_NW'({mulx, 1'b0}) + DIV2_NW'(len);
      num5[1] <= DIV2_NW'({muly, 1'b0}) + DIV2_NW'(len);
      div5[0] <= DIV2_W'({len, 1'b0});
      div5[1] <= DIV2_W'({len, 1'b0});
      sb5     <= sb5_c;
    end
  end

  logic               vd2;
  logic [1:0][QW-1:0] q2;
  div2_side_t         sbd2;

  cgcv_rdiv #(
    .LANES(2),
    .QW   (QW),
    .DW   (DIV2_W),
    .SW   ($bits(div2_side_t))
  ) u_div_circle (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .num      (num5),
    .div      (div5),
    .in_side  (sb5),
    .out_valid(vd2),
    .quo      (q2),
    .out_side (sbd2)
  );

  // Stage 6: signs, bypass for a zero length, and invalid faces.
  logic [QW-1:0]      xm;
  logic [QW-1:0]      ym;
  logic [COORD_W-1:0] x_c;
  logic [COORD_W-1:0] y_c;
  logic [COORD_W-1:0] z_c;
  logic [IDX_W-1:0]   i_c;

  always_comb begin
    xm = sbd2.zero_len ? sbd2.qx : q2[0];
    ym = sbd2.zero_len ? sbd2.qy : q2[1];
    if (sbd2.ok) begin
      x_c = sbd2.sx ? (COORD_W'(0) - xm) : xm;
      y_c = sbd2.sy ? (COORD_W'(0) - ym) : ym;
      z_c = sbd2.z;
      i_c = sbd2.idx;
    end else begin
      x_c = '0;
      y_c = '0;
      z_c = '0;
      i_c = '0;
    end
  end

  logic               v6;
  logic [COORD_W-1:0] x6;
  logic [COORD_W-1:0] y6;
  logic [COORD_W-1:0] z6;
  logic [IDX_W-1:0]   i6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x6 <= x_c;
      y6 <= y_c;
      z6 <= z_c;
      i6 <= i_c;
    end
  end

  logic [COORD_W-1:0] skid_x;
  logic [COORD_W-1:0] skid_y;
  logic [COORD_W-1:0] skid_z;
  logic [IDX_W-1:0]   skid_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full && v6 && out_stall) begin
      skid_full <= 1'b1;
    end else if (skid_full && !out_stall) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && v6 && out_stall) begin
      skid_x <= x6;
      skid_y <= y6;
      skid_z <= z6;
      skid_i <= i6;
    end
  end

  assign out_valid    = skid_full || v6;
  assign x_out        = $signed(skid_full ? skid_x : x6);
  assign y_out        = $signed(skid_full ? skid_y : y6);
  assign z_out        = $signed(skid_full ? skid_z : z6);
  assign vertex_index = skid_full ? skid_i : i6;

endmodule

/* src/cgcv_checker.sv */
module cgcv_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                pready,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cgcv_pkg::COORD_W-1:0] x_out,
  input logic signed [cgcv_pkg::COORD_W-1:0] y_out,
  input logic signed [cgcv_pkg::COORD_W-1:0] z_out,
  input logic [cgcv_pkg::IDX_W-1:0]          vertex_index
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("Configuration port was not ready.");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("Block was not idle after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("Input stalled without a stalled output transfer.");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Input stalled while no result was offered.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(y_out)
      && $stable(z_out) && $stable(vertex_index))
    else $error("Stalled result changed.");

endmodule

bind cube_grid_to_cylinder_vertex_core cgcv_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pready      (pready),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .x_out       (x_out),
  .y_out       (y_out),
  .z_out       (z_out),
  .vertex_index(vertex_index)
);
